// ===== src/i2cee_pkg.sv =====
// Package for the I2C EEPROM byte master: phase codes, config and result types,
// register indexes and the per-phase line tables. No dependencies.
`timescale 1ns / 1ps

package i2cee_pkg;

    localparam int HP_W      = 16;  // half-period and tick counter width
    localparam int LIMIT_W   = 8;
    localparam int DEV_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE      = 2'd2;

    localparam logic [HP_W-1:0]    HALF_PERIOD_RST = 16'd250;
    localparam logic [LIMIT_W-1:0] ACK_LIMIT_RST   = 8'd250;
    localparam logic [DEV_W-1:0]   DEVICE_RST      = 7'd80;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_START_B   = 5'd2,
        PH_TX_LOW    = 5'd3,
        PH_TX_HIGH   = 5'd4,
        PH_ACK_LOW   = 5'd5,
        PH_ACK_HIGH  = 5'd6,
        PH_RS_LOW    = 5'd7,
        PH_RX_LOW    = 5'd8,
        PH_RX_HIGH   = 5'd9,
        PH_NACK_LOW  = 5'd10,
        PH_NACK_HIGH = 5'd11,
        PH_STOP_A    = 5'd12,
        PH_STOP_B    = 5'd13,
        PH_STOP_C    = 5'd14
    } phase_t;

    typedef enum logic [1:0] {
        STAGE_DEVICE = 2'd0,
        STAGE_WORD   = 2'd1,
        STAGE_PAYLOAD = 2'd2,
        STAGE_SPARE  = 2'd3
    } byte_stage_t;

    typedef struct packed {
        logic [HP_W-1:0]    half_period_ticks;
        logic [LIMIT_W-1:0] ack_wait_limit;
        logic [DEV_W-1:0]   device_select;
    } cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic       req_type;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_missing;
    } res_t;

    function automatic logic scl_of_phase(input phase_t p);
        logic v;
        unique case (p)
            PH_TX_LOW, PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW,
            PH_NACK_LOW, PH_STOP_A: v = 1'b0;
            default:                v = 1'b1;
        endcase
        return v;
    endfunction

    function automatic logic sda_of_phase(input phase_t p);
        logic v;
        unique case (p)
            PH_START_B, PH_TX_LOW, PH_TX_HIGH,
            PH_STOP_A, PH_STOP_B: v = 1'b0;
            default:              v = 1'b1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/i2cee_item_if.sv =====
// Input channel: one tick beat with command fields and sampled SDA.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface i2cee_item_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic       req_type;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, cmd_valid, req_type, word_address, write_data, sda_in,
                    input ready);
    modport sink   (input valid, cmd_valid, req_type, word_address, write_data, sda_in,
                    output ready);
endinterface

// ===== src/i2cee_result_if.sv =====
// Output channel: one result beat per tick with bus levels and status.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface i2cee_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;

    modport source (output valid, scl_level, sda_release, busy_res, done_res, read_byte,
                    ack_missing, input ready);
    modport sink   (input valid, scl_level, sda_release, busy_res, done_res, read_byte,
                    ack_missing, output ready);
endinterface

// ===== src/i2cee_cfg_regs.sv =====
// Configuration register file: half period, ack wait limit, device address.
// Depends on i2cee_pkg.
`timescale 1ns / 1ps

module i2cee_cfg_regs
    import i2cee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_next.half_period_ticks = cfg_wdata[HP_W-1:0];
                CFG_ACK_LIMIT:   cfg_next.ack_wait_limit    = cfg_wdata[LIMIT_W-1:0];
                CFG_DEVICE:      cfg_next.device_select     = cfg_wdata[DEV_W-1:0];
                default:         cfg_next = cfg_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.ack_wait_limit    <= ACK_LIMIT_RST;
            cfg_reg.device_select     <= DEVICE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/i2cee_seq.sv =====
// Bus sequencer: phase state machine, bit shifter, tick and ack-wait counters.
// Advances one tick per accepted beat. Depends on i2cee_pkg.
`timescale 1ns / 1ps

module i2cee_seq
    import i2cee_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res,
    output logic  idle
);

    phase_t            phase_reg, phase_next;
    byte_stage_t       stage_reg, stage_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [HP_W-1:0]   tick_reg, tick_next;
    logic [LIMIT_W-1:0] wait_reg, wait_next;
    logic [7:0]        addr_reg, addr_next;
    logic [7:0]        data_reg, data_next;
    logic              kind_reg, kind_next;
    logic [7:0]        recv_reg, recv_next;
    logic              fault_reg, fault_next;

    logic [HP_W:0]     tick_inc;
    logic [HP_W-1:0]   target;
    logic              tick_hit;
    logic [3:0]        bit_inc;
    logic [7:0]        rx_shift;

    // Zero half period behaves as one.
    assign target   = (cfg.half_period_ticks == '0) ? HP_W'(1) : cfg.half_period_ticks;
    assign tick_inc = {1'b0, tick_reg} + (HP_W+1)'(1);
    assign tick_hit = tick_inc >= {1'b0, target};
    assign bit_inc  = bit_reg + 4'd1;
    assign rx_shift = {shift_reg[6:0], item.sda_in};

    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        wait_next  = wait_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        recv_next  = recv_reg;
        fault_next = fault_reg;

        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item.cmd_valid)
                    begin
                        addr_next  = item.word_address;
                        data_next  = item.write_data;
                        kind_next  = item.req_type;
                        fault_next = 1'b0;
                        stage_next = STAGE_DEVICE;
                        bit_next   = 4'd0;
                        tick_next  = '0;
                        phase_next = PH_START_A;
                    end
                end
                PH_ACK_HIGH:
                begin
                    if (!item.sda_in || (wait_reg >= cfg.ack_wait_limit))
                    begin
                        if (item.sda_in)
                            fault_next = 1'b1;
                        tick_next = '0;
                        unique case (stage_reg)
                            STAGE_DEVICE:
                            begin
                                stage_next = STAGE_WORD;
                                shift_next = addr_reg;
                                bit_next   = 4'd0;
                                phase_next = PH_TX_LOW;
                            end
                            STAGE_WORD:
                            begin
                                stage_next = STAGE_PAYLOAD;
                                if (!kind_reg)
                                begin
                                    shift_next = data_reg;
                                    bit_next   = 4'd0;
                                    phase_next = PH_TX_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_RS_LOW;
                                end
                            end
                            default:
                            begin
                                if (!kind_reg)
                                begin
                                    phase_next = PH_STOP_A;
                                end
                                else
                                begin
                                    shift_next = 8'd0;
                                    bit_next   = 4'd0;
                                    phase_next = PH_RX_LOW;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        wait_next = wait_reg + LIMIT_W'(1);
                    end
                end
                PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_RS_LOW,
                PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_A, PH_STOP_B,
                PH_STOP_C:
                begin
                    tick_next = tick_inc[HP_W-1:0];
                    if (tick_hit)
                    begin
                        tick_next = '0;
                        unique case (phase_reg)
                            PH_START_A: phase_next = PH_START_B;
                            PH_START_B:
                            begin
                                shift_next = {cfg.device_select, stage_reg != STAGE_DEVICE};
                                bit_next   = 4'd0;
                                phase_next = PH_TX_LOW;
                            end
                            PH_TX_LOW: phase_next = PH_TX_HIGH;
                            PH_TX_HIGH:
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bit_next   = bit_inc;
                                phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW
                                                                        : PH_TX_LOW;
                            end
                            PH_ACK_LOW:
                            begin
                                wait_next  = '0;
                                phase_next = PH_ACK_HIGH;
                            end
                            PH_RS_LOW: phase_next = PH_START_A;
                            PH_RX_LOW: phase_next = PH_RX_HIGH;
                            PH_RX_HIGH:
                            begin
                                shift_next = rx_shift;
                                bit_next   = bit_inc;
                                if (bit_inc >= BITS_PER_BYTE)
                                begin
                                    recv_next  = rx_shift;
                                    phase_next = PH_NACK_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_RX_LOW;
                                end
                            end
                            PH_NACK_LOW:  phase_next = PH_NACK_HIGH;
                            PH_NACK_HIGH: phase_next = PH_STOP_A;
                            PH_STOP_A:    phase_next = PH_STOP_B;
                            PH_STOP_B:    phase_next = PH_STOP_C;
                            default:      phase_next = PH_IDLE;
                        endcase
                    end
                end
                default:
                begin
                    // Unknown code: fall back to idle.
                    tick_next  = '0;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result reflects the state after this tick.
    always_comb
    begin
        res.scl_level   = scl_of_phase(phase_next);
        res.sda_release = ((phase_next == PH_TX_LOW) || (phase_next == PH_TX_HIGH))
                          ? shift_next[7] : sda_of_phase(phase_next);
        res.busy_res    = phase_next != PH_IDLE;
        res.done_res    = (phase_reg == PH_STOP_C) && tick_hit;
        res.read_byte   = recv_next;
        res.ack_missing = fault_next;
    end

    assign idle = phase_reg == PH_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stage_reg <= STAGE_DEVICE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            tick_reg  <= '0;
            wait_reg  <= '0;
            addr_reg  <= 8'd0;
            data_reg  <= 8'd0;
            kind_reg  <= 1'b0;
            recv_reg  <= 8'd0;
            fault_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            wait_reg  <= wait_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            kind_reg  <= kind_next;
            recv_reg  <= recv_next;
            fault_reg <= fault_next;
        end
    end

endmodule

// ===== src/i2cee_out_stage.sv =====
// Result register between the sequencer and the output channel.
// Depends on i2cee_pkg and i2cee_result_if.
`timescale 1ns / 1ps

module i2cee_out_stage
    import i2cee_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  res_t            res,
    output logic            can_load,
    i2cee_result_if.source  result
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign can_load = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign result.valid       = valid_reg;
    assign result.scl_level   = data_reg.scl_level;
    assign result.sda_release = data_reg.sda_release;
    assign result.busy_res    = data_reg.busy_res;
    assign result.done_res    = data_reg.done_res;
    assign result.read_byte   = data_reg.read_byte;
    assign result.ack_missing = data_reg.ack_missing;

endmodule

// ===== src/i2c_eeprom_byte_master.sv =====
// Top level of the I2C EEPROM byte master: config registers, sequencer, result register.
// Depends on i2cee_pkg, both channel interfaces and the three submodules.
`timescale 1ns / 1ps

// I2C master for a byte-addressed serial EEPROM. Each beat on the item channel is one
// timing tick: it carries the sampled SDA level and, when cmd_valid is set while the
// sequencer is idle, a command (req_type 0 = byte write, 1 = random byte read). Every
// tick yields exactly one result beat giving the SCL drive level, the SDA release flag,
// busy, a done pulse on the tick the stop completes, the last read byte and a sticky
// missing-acknowledge flag for the current transaction. A write sends start, device
// write address, word address, data and stop; a read adds a repeated start, the device
// read address, eight clocked-in bits MSB first, a master NACK clock and stop. Each
// SCL phase lasts half_period_ticks ticks (0 acts as 1); at every ack clock SCL stays
// high until SDA is seen low or SDA has been seen high on ack_wait_limit + 1 ticks,
// and the transfer continues either way. Rate: one beat per clock while the sink keeps
// taking result beats. The sequencer's state update is a single short pass from its state
// registers into the result register; item.ready drops only while the result register
// holds a beat that the sink has not taken. Configuration (index 0 half period, 1 ack
// limit, 2 device address) is written through cfg_we/cfg_index/cfg_wdata and takes
// effect on the next tick.
module i2c_eeprom_byte_master
    import i2cee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    i2cee_item_if.sink           item,
    i2cee_result_if.source       result
);

    cfg_t  cfg;
    item_t item_beat;
    res_t  seq_res;
    logic  seq_idle;
    logic  can_load;
    logic  step;

    // Accept a tick whenever the result register can take its answer.
    assign item.ready = can_load;
    assign step       = item.valid && can_load;

    assign item_beat.cmd_valid    = item.cmd_valid;
    assign item_beat.req_type     = item.req_type;
    assign item_beat.word_address = item.word_address;
    assign item_beat.write_data   = item.write_data;
    assign item_beat.sda_in       = item.sda_in;

    i2cee_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the bus sequencer by one tick per accepted beat.
    i2cee_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_beat),
        .cfg   (cfg),
        .res   (seq_res),
        .idle  (seq_idle)
    );

    // Hold the tick's result until the sink takes it.
    i2cee_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (seq_res),
        .can_load (can_load),
        .result   (result)
    );

    // Every accepted tick shows up as a result beat on the next cycle.
    a_tick_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> result.valid)
        else $error("accepted tick produced no result beat");

    // The stop-complete pulse comes with the sequencer already idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.done_res) |-> !result.busy_res)
        else $error("done reported while still busy");

    // With no transaction running both lines are released.
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.busy_res) |-> (result.scl_level && result.sda_release))
        else $error("bus driven while idle");

    // An idle tick without a command stays idle.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && seq_idle && !item.cmd_valid) |=> (result.valid && !result.busy_res))
        else $error("sequencer left idle without a command");

endmodule
